/* design/nlq_pkg.sv */
// Package for the nearest level quantizer: table size, value width,
// command codes and the search pipeline stage record. No dependencies.
package nlq_pkg;

  localparam int MAX_LEVELS  = 256;
  localparam int VALUE_WIDTH = 16;
  localparam int SLOT_W      = 8;
  localparam int TAG_W       = 16;
  localparam int COUNT_W     = 9;

  localparam int IDX_W = $clog2(MAX_LEVELS);
  localparam int CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int ITERS = $clog2(MAX_LEVELS + 1);

  localparam logic CMD_WRITE    = 1'b0;
  localparam logic CMD_QUANTIZE = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic [SLOT_W-1:0]             slot;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [TAG_W-1:0]              tag;
    logic [CNT_W-1:0]              lo;
    logic [CNT_W-1:0]              hip1;
    logic [CNT_W-1:0]              mid;
    logic                          have_best;
    logic [VALUE_WIDTH-1:0]        best_dist;
    logic [IDX_W-1:0]              best_slot;
    logic signed [VALUE_WIDTH-1:0] best_level;
  } stage_t;

endpackage

/* design/nlq_if.sv */
// Handshake channels of the nearest level quantizer: input items and
// result items. Depends on nlq_pkg.
interface nlq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  command;
  logic [nlq_pkg::SLOT_W-1:0]            slot;
  logic signed [nlq_pkg::VALUE_WIDTH-1:0] value;
  logic [nlq_pkg::TAG_W-1:0]             sample_tag;

  modport source (output valid, command, slot, value, sample_tag, input ready);
  modport sink   (input valid, command, slot, value, sample_tag, output ready);
endinterface

interface nlq_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [nlq_pkg::VALUE_WIDTH-1:0] quantized_value;
  logic [nlq_pkg::SLOT_W-1:0]            chosen_slot;
  logic [nlq_pkg::TAG_W-1:0]             result_tag;

  modport source (output valid, quantized_value, chosen_slot, result_tag, input ready);
  modport sink   (input valid, quantized_value, chosen_slot, result_tag, output ready);
endinterface

/* design/nearest_level_quantizer.sv */
// Nearest level quantizer: pipelined binary search over a level table.
// Each search step has a table read stage on its own table copy and a
// compare/update stage. Throughput one item per cycle; a full output
// stalls the whole pipeline. Reset clears valid bits and sets count_q
// to 2; table contents are undefined until written. Depends on nlq_pkg
// and nlq_if.
module nearest_level_quantizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [nlq_pkg::COUNT_W-1:0] cfg_wdata_i,
  nlq_in_if.sink                      in_i,
  nlq_out_if.source                   out_o
);
  import nlq_pkg::*;

  logic [COUNT_W-1:0] count_q;
  logic               en;

  stage_t                        a_q   [ITERS];
  stage_t                        b_q   [ITERS];
  stage_t                        nxt   [ITERS];
  logic signed [VALUE_WIDTH-1:0] rdata_q [ITERS];
  logic [ITERS-1:0]              a_vld_q;
  logic [ITERS-1:0]              b_vld_q;

  stage_t out_q;
  logic   out_vld_q;

  stage_t           init;
  logic [CNT_W-1:0] cnt_eff;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_W'(2);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (32'(count_q) > MAX_LEVELS) begin
      cnt_eff = CNT_W'(MAX_LEVELS);
    end else if (count_q < COUNT_W'(2)) begin
      cnt_eff = CNT_W'(2);
    end else begin
      cnt_eff = CNT_W'(count_q);
    end
  end

  always_comb begin
    init            = '0;
    init.cmd        = in_i.command;
    init.slot       = in_i.slot;
    init.value      = in_i.value;
    init.tag        = in_i.sample_tag;
    init.lo         = '0;
    init.hip1       = cnt_eff;
    init.mid        = (cnt_eff - CNT_W'(1)) >> 1;
    init.have_best  = 1'b0;
  end

  // one binary search step on a stage record and the level read at its mid
  function automatic stage_t search_step(stage_t s, logic signed [VALUE_WIDTH-1:0] lv);
    stage_t                      r;
    logic signed [VALUE_WIDTH:0] diff;
    logic [VALUE_WIDTH:0]        mag;
    logic [VALUE_WIDTH-1:0]      delta;
    logic [CNT_W-1:0]            nlo;
    logic [CNT_W-1:0]            nhi;
    r     = s;
    diff  = {s.value[VALUE_WIDTH-1], s.value} - {lv[VALUE_WIDTH-1], lv};
    mag   = diff[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(0) - diff : diff;
    delta = mag[VALUE_WIDTH-1:0];
    nlo   = s.lo;
    nhi   = s.hip1;
    if (s.cmd == CMD_QUANTIZE && s.lo < s.hip1) begin
      if (!s.have_best || delta < s.best_dist) begin
        r.have_best  = 1'b1;
        r.best_dist  = delta;
        r.best_slot  = s.mid[IDX_W-1:0];
        r.best_level = lv;
      end
      if (lv < s.value) begin
        nlo = s.mid + CNT_W'(1);
      end else begin
        nhi = s.mid;
      end
      r.lo   = nlo;
      r.hip1 = nhi;
      r.mid  = nlo + ((nhi - nlo - CNT_W'(1)) >> 1);
    end
    return r;
  endfunction

  for (genvar k = 0; k < ITERS; k++) begin : g_step
    logic signed [VALUE_WIDTH-1:0] mem_q [MAX_LEVELS];

    // writes move down the pipeline so each copy sees items in order
    always_ff @(posedge clk_i) begin
      if (en && a_vld_q[k] && a_q[k].cmd == CMD_WRITE && 32'(a_q[k].slot) < MAX_LEVELS) begin
        mem_q[IDX_W'(a_q[k].slot)] <= a_q[k].value;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rdata_q[k] <= mem_q[a_q[k].mid[IDX_W-1:0]];
        b_q[k]     <= a_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_vld_q[k] <= 1'b0;
      end else if (en) begin
        b_vld_q[k] <= a_vld_q[k];
      end
    end

    assign nxt[k] = search_step(b_q[k], rdata_q[k]);

    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en) begin
          a_q[k] <= init;
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          a_vld_q[k] <= 1'b0;
        end else if (en) begin
          a_vld_q[k] <= in_i.valid;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en) begin
          a_q[k] <= nxt[k-1];
        end
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          a_vld_q[k] <= 1'b0;
        end else if (en) begin
          a_vld_q[k] <= b_vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= nxt[ITERS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= b_vld_q[ITERS-1] && b_q[ITERS-1].cmd == CMD_QUANTIZE;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.quantized_value = out_q.best_level;
  assign out_o.chosen_slot     = SLOT_W'(out_q.best_slot);
  assign out_o.result_tag      = out_q.tag;

  // stalled pipeline keeps every item in place
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(a_vld_q) && $stable(b_vld_q))
    else $error("pipeline valid bits changed during stall");

  // search must be finished after the last step
  a_search_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld_q[ITERS-1] && b_q[ITERS-1].cmd == CMD_QUANTIZE
      |-> !(nxt[ITERS-1].lo < nxt[ITERS-1].hip1))
    else $error("binary search not finished at last stage");

  // every result carries a chosen midpoint
  a_result_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.have_best)
    else $error("result without a chosen level");

  // an accepted input item enters stage zero
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && in_i.valid |=> a_vld_q[0])
    else $error("accepted item lost at pipeline entry");

endmodule
